@@ src/hhpid_pkg.sv @@
// Shared types and constants for the heading-hold PID drive controller.
// No dependencies; every other file in src/ refers to it by scoped names.
`timescale 1ns / 1ps

package hhpid_pkg;

    // Default width of the running error sum and its previous value
    localparam int SUM_WIDTH_DEF = 32;

    // Drives are clamped to +/- this value
    localparam int DRIVE_LIMIT = 125;

    // Bearing geometry, tenths of a degree
    localparam logic [11:0]        FULL_TURN_U = 12'd3600;
    localparam logic signed [13:0] FULL_TURN_S = 14'sd3600;
    localparam logic signed [13:0] HALF_TURN_S = 14'sd1800;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_K_PROP    = 2'd0,
        CFG_KI_SCALED = 2'd1,
        CFG_KD_SCALED = 2'd2
    } t_cfg_index;

    // One input word
    typedef struct packed {
        logic [11:0]        bearing_tenths;
        logic               hold_enable;
        logic signed [7:0]  left_request;
        logic signed [7:0]  right_request;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic signed [7:0]  left_drive;
        logic signed [7:0]  right_drive;
        logic               left_changed;
        logic               right_changed;
        logic signed [11:0] heading_error;
    } t_out_word;

    // Control handed from the error stage to the drive stage
    typedef struct packed {
        logic valid;  // stage holds a word
        logic hold;   // heading hold on for this word
        logic latch;  // first held word: capture the last sent drives
    } t_stage_ctrl;

endpackage

@@ src/hhpid_error.sv @@
// Error stage: wrapped heading error, saturating error sum and input register.
// Depends on hhpid_pkg.
`timescale 1ns / 1ps

module hhpid_error #(
    parameter int SUM_WIDTH = hhpid_pkg::SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  hhpid_pkg::t_in_word         i_word,
    input  logic                        i_take,
    output hhpid_pkg::t_stage_ctrl      o_ctrl,
    output logic signed [11:0]          o_err,
    output logic signed [SUM_WIDTH-1:0] o_sum,
    output logic signed [SUM_WIDTH:0]   o_diff,
    output logic signed [7:0]           o_left_request,
    output logic signed [7:0]           o_right_request
);

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // Heading state
    logic                        r_hold_active;
    logic [11:0]                 r_latched_bearing;
    logic signed [SUM_WIDTH-1:0] r_error_sum;
    logic signed [SUM_WIDTH-1:0] r_previous_sum;

    // Stage register
    logic                        r_valid;
    logic                        r_hold;
    logic                        r_latch;
    logic signed [11:0]          r_err;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [SUM_WIDTH:0]   r_diff;
    logic signed [7:0]           r_lreq;
    logic signed [7:0]           r_rreq;

    logic                        w_accept;
    logic [11:0]                 w_bearing;
    logic [11:0]                 w_ref;
    logic signed [13:0]          w_b;
    logic signed [13:0]          w_s;
    logic signed [13:0]          w_wrap;
    logic signed [11:0]          w_err;
    logic signed [SUM_WIDTH:0]   w_sum_ext;
    logic signed [SUM_WIDTH-1:0] w_sum_sat;
    logic signed [SUM_WIDTH-1:0] w_sum_new;
    logic signed [SUM_WIDTH:0]   w_diff;

    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        // reduce out-of-range bearings by one turn
        w_bearing = (i_word.bearing_tenths >= hhpid_pkg::FULL_TURN_U)
                  ? i_word.bearing_tenths - hhpid_pkg::FULL_TURN_U
                  : i_word.bearing_tenths;
        w_ref = r_hold_active ? r_latched_bearing : w_bearing;
        w_b   = $signed({2'b00, w_bearing});
        w_s   = $signed({2'b00, w_ref});

        if (w_s >= hhpid_pkg::HALF_TURN_S) begin
            if (w_b >= w_s - hhpid_pkg::HALF_TURN_S) begin
                w_wrap = w_b - w_s;
            end else begin
                w_wrap = w_b + hhpid_pkg::FULL_TURN_S - w_s;
            end
        end else if ((w_b >= w_s && w_b - hhpid_pkg::HALF_TURN_S <= w_s)
                     || w_b <= hhpid_pkg::HALF_TURN_S) begin
            w_wrap = w_b - w_s;
        end else begin
            w_wrap = w_b - hhpid_pkg::FULL_TURN_S - w_s;
        end

        w_err = i_word.hold_enable ? w_wrap[11:0] : 12'sd0;

        // saturating accumulate
        w_sum_ext = (SUM_WIDTH+1)'(r_error_sum) + (SUM_WIDTH+1)'(w_err);
        if (w_sum_ext[SUM_WIDTH] != w_sum_ext[SUM_WIDTH-1]) begin
            w_sum_sat = w_sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sum_sat = w_sum_ext[SUM_WIDTH-1:0];
        end
        w_sum_new = i_word.hold_enable ? w_sum_sat : r_error_sum;
        w_diff    = (SUM_WIDTH+1)'(w_sum_new) - (SUM_WIDTH+1)'(r_previous_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_active     <= 1'b0;
            r_latched_bearing <= '0;
            r_error_sum       <= '0;
            r_previous_sum    <= '0;
            r_valid           <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                if (i_word.hold_enable) begin
                    r_hold_active     <= 1'b1;
                    r_latched_bearing <= w_ref;
                    r_error_sum       <= w_sum_new;
                    r_previous_sum    <= w_sum_new;
                end else begin
                    // drop the latch, keep the sums
                    r_hold_active <= 1'b0;
                end
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hold  <= i_word.hold_enable;
            r_latch <= i_word.hold_enable && !r_hold_active;
            r_err   <= w_err;
            r_sum   <= w_sum_new;
            r_diff  <= w_diff;
            r_lreq  <= i_word.left_request;
            r_rreq  <= i_word.right_request;
        end
    end

    assign o_ctrl.valid    = r_valid;
    assign o_ctrl.hold     = r_hold;
    assign o_ctrl.latch    = r_latch;
    assign o_err           = r_err;
    assign o_sum           = r_sum;
    assign o_diff          = r_diff;
    assign o_left_request  = r_lreq;
    assign o_right_request = r_rreq;

endmodule

@@ src/hhpid_drive.sv @@
// Drive stage: PID products, drive correction, clamp, change flags, result register.
// Depends on hhpid_pkg.
`timescale 1ns / 1ps

module hhpid_drive #(
    parameter int SUM_WIDTH = hhpid_pkg::SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hhpid_pkg::t_stage_ctrl      i_ctrl,
    input  logic signed [11:0]          i_err,
    input  logic signed [SUM_WIDTH-1:0] i_sum,
    input  logic signed [SUM_WIDTH:0]   i_diff,
    input  logic signed [7:0]           i_left_request,
    input  logic signed [7:0]           i_right_request,
    input  logic signed [15:0]          i_k_prop,
    input  logic signed [15:0]          i_ki_scaled,
    input  logic signed [15:0]          i_kd_scaled,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output hhpid_pkg::t_out_word        o_out_word
);

    localparam int ACC_W = SUM_WIDTH + 19;
    localparam int CHG_W = ACC_W - 8;
    localparam int D_W   = CHG_W + 1;
    localparam logic signed [D_W-1:0] LIM_HI = D_W'(hhpid_pkg::DRIVE_LIMIT);
    localparam logic signed [D_W-1:0] LIM_LO = -LIM_HI;

    function automatic logic signed [7:0] clamp_drive(input logic signed [D_W-1:0] v);
        logic signed [7:0] res;
        if (v > LIM_HI) begin
            res = LIM_HI[7:0];
        end else if (v < LIM_LO) begin
            res = LIM_LO[7:0];
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    logic                      r_out_valid;
    hhpid_pkg::t_out_word      r_out_word;
    logic signed [7:0]         r_left_actual;
    logic signed [7:0]         r_right_actual;
    logic signed [7:0]         r_latched_left;
    logic signed [7:0]         r_latched_right;

    logic                      w_load;
    logic signed [27:0]        w_p_prop;
    logic signed [SUM_WIDTH+15:0] w_p_int;
    logic signed [SUM_WIDTH+16:0] w_p_der;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_acc_adj;
    logic signed [CHG_W-1:0]   w_change;
    logic signed [D_W-1:0]     w_chg;
    logic signed [7:0]         w_lat_l;
    logic signed [7:0]         w_lat_r;
    logic signed [D_W-1:0]     w_lset;
    logic signed [D_W-1:0]     w_rset;
    logic signed [7:0]         w_left;
    logic signed [7:0]         w_right;

    assign o_take = !r_out_valid || i_out_ready;
    assign w_load = i_ctrl.valid && o_take;

    // Q8.8 PID terms, all three in parallel
    assign w_p_prop = i_k_prop * i_err;
    assign w_p_int  = i_ki_scaled * i_sum;
    assign w_p_der  = i_kd_scaled * i_diff;

    always_comb begin
        w_acc = ACC_W'(w_p_prop) + ACC_W'(w_p_int) + ACC_W'(w_p_der);
        // divide by 256, truncating toward zero
        w_acc_adj = w_acc[ACC_W-1] ? w_acc + ACC_W'(255) : w_acc;
        w_change  = w_acc_adj[ACC_W-1:8];
        w_chg     = D_W'(w_change);

        w_lat_l = i_ctrl.latch ? r_left_actual  : r_latched_left;
        w_lat_r = i_ctrl.latch ? r_right_actual : r_latched_right;

        if (i_ctrl.hold) begin
            w_lset = D_W'(w_lat_l);
            w_rset = D_W'(w_lat_r);
            if (w_chg < 0) begin
                // slow the right motor
                w_rset = (w_lat_r > 0) ? D_W'(w_lat_r) + w_chg : D_W'(w_lat_r) - w_chg;
            end else if (w_chg > 0) begin
                // slow the left motor
                w_lset = (w_lat_l > 0) ? D_W'(w_lat_l) - w_chg : D_W'(w_lat_l) + w_chg;
            end
        end else begin
            w_lset = D_W'(i_left_request);
            w_rset = D_W'(i_right_request);
        end

        w_left  = clamp_drive(w_lset);
        w_right = clamp_drive(w_rset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_left_actual   <= '0;
            r_right_actual  <= '0;
            r_latched_left  <= '0;
            r_latched_right <= '0;
        end else begin
            if (w_load) begin
                r_out_valid    <= 1'b1;
                r_left_actual  <= w_left;
                r_right_actual <= w_right;
                if (i_ctrl.latch) begin
                    r_latched_left  <= r_left_actual;
                    r_latched_right <= r_right_actual;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word.left_drive    <= w_left;
            r_out_word.right_drive   <= w_right;
            r_out_word.left_changed  <= (w_left != r_left_actual);
            r_out_word.right_changed <= (w_right != r_right_actual);
            r_out_word.heading_error <= i_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ src/heading_hold_pid_differential_drive.sv @@
// Top level of the heading-hold PID controller for a differential drive.
// Depends on hhpid_pkg, hhpid_error and hhpid_drive.
//
// Usage: each input word on i_in_* is one control tick (bearing in tenths of
// a degree, hold enable, left/right requests). Each accepted word gives one
// result word on o_out_* with the clamped drives, change flags and the
// wrapped heading error. Both channels are valid/ready.
// Path: error stage register, then the PID/drive stage, then the result register.
// Throughput: one word per cycle unless the receiver stalls; the three gain
// multiplies and the drive correction sit in one pass between the stage register
// and the result register. Gains are written on the plain i_cfg_* port by the
// user only while the block is idle; the block itself does not enforce this.
// Reset: synchronous, active low; clears the hold latch, sums, last sent
// drives and both valid flags, and loads the default gains (k_prop = 1.0).
// Stall: while the receiver holds o_out_valid unanswered, the stage register
// keeps one more word, then o_in_ready falls until the result is taken.
`timescale 1ns / 1ps

module heading_hold_pid_differential_drive #(
    parameter int SUM_WIDTH = hhpid_pkg::SUM_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hhpid_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hhpid_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // Gain registers, signed Q8.8
    logic signed [15:0] r_k_prop;
    logic signed [15:0] r_ki_scaled;
    logic signed [15:0] r_kd_scaled;

    hhpid_pkg::t_stage_ctrl      w_ctrl;
    logic signed [11:0]          w_err;
    logic signed [SUM_WIDTH-1:0] w_sum;
    logic signed [SUM_WIDTH:0]   w_diff;
    logic signed [7:0]           w_lreq;
    logic signed [7:0]           w_rreq;
    logic                        w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_prop    <= 16'sd256;
            r_ki_scaled <= '0;
            r_kd_scaled <= '0;
        end else if (i_cfg_we) begin
            unique case (hhpid_pkg::t_cfg_index'(i_cfg_index))
                hhpid_pkg::CFG_K_PROP:    r_k_prop    <= i_cfg_data;
                hhpid_pkg::CFG_KI_SCALED: r_ki_scaled <= i_cfg_data;
                hhpid_pkg::CFG_KD_SCALED: r_kd_scaled <= i_cfg_data;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // Error stage: bearing wrap, hold latch, error sum
    hhpid_error #(
        .SUM_WIDTH(SUM_WIDTH)
    ) u_error (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_word          (i_in_word),
        .i_take          (w_take),
        .o_ctrl          (w_ctrl),
        .o_err           (w_err),
        .o_sum           (w_sum),
        .o_diff          (w_diff),
        .o_left_request  (w_lreq),
        .o_right_request (w_rreq)
    );

    // Drive stage: PID change, drive correction, result register
    hhpid_drive #(
        .SUM_WIDTH(SUM_WIDTH)
    ) u_drive (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_err           (w_err),
        .i_sum           (w_sum),
        .i_diff          (w_diff),
        .i_left_request  (w_lreq),
        .i_right_request (w_rreq),
        .i_k_prop        (r_k_prop),
        .i_ki_scaled     (r_ki_scaled),
        .i_kd_scaled     (r_kd_scaled),
        .o_take          (w_take),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_word      (o_out_word)
    );

    localparam logic signed [7:0] LIM = 8'(hhpid_pkg::DRIVE_LIMIT);

    // Result drives always sit inside the clamp window
    a_drive_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.left_drive <= LIM && o_out_word.left_drive >= -LIM
                         && o_out_word.right_drive <= LIM
                         && o_out_word.right_drive >= -LIM))
        else $error("drive outside clamp window");

    // Input backpressure only when both stages are full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_ctrl.valid && o_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    // Heading error is zero for words passed through with hold off
    a_err_hold_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.valid && !w_ctrl.hold) |-> (w_err == 12'sd0))
        else $error("nonzero heading error with hold off");

    // A latch request is always a held word
    a_latch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.valid && w_ctrl.latch) |-> w_ctrl.hold)
        else $error("drive latch without hold");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for heading_hold_pid_differential_drive.
// Depends on hhpid_pkg and the RTL in src/. A scoreboard class predicts each
// result word from its own copy of the PID state. Plain tasks drive the block.
`timescale 1ns / 1ps

module tb;
    import hhpid_pkg::*;

    // Run at the block's default error-sum width
    localparam int SUM_W       = SUM_WIDTH_DEF;
    localparam int STALL_LEN   = 400;   // long receiver hold-off, in cycles
    localparam int QUIET_LIMIT = 3000;  // cycles with no accepted word before giving up
    localparam int PHASE_ITEMS = 185;

    typedef enum int {RUN_DRIFT, RUN_PUSH, RUN_WIDE} run_kind_e;

    // Scoreboard: predicts the drive word for each accepted tick and checks
    // results against the oldest prediction.
    class drive_scoreboard;
        localparam longint TURN = 3600;
        localparam longint HALF = 1800;

        longint    k_prop, ki_scaled, kd_scaled;
        bit        hold_on;
        longint    held_bearing, held_left, held_right;
        longint    err_sum, prev_sum, left_sent, right_sent;
        t_out_word expected_drives[$];
        int        drive_mismatches;

        function new();
            k_prop           = 256;
            ki_scaled        = 0;
            kd_scaled        = 0;
            hold_on          = 1'b0;
            held_bearing     = 0;
            held_left        = 0;
            held_right       = 0;
            err_sum          = 0;
            prev_sum         = 0;
            left_sent        = 0;
            right_sent       = 0;
            drive_mismatches = 0;
        endfunction

        function void set_gain(t_cfg_index idx, logic [15:0] value);
            case (idx)
                CFG_K_PROP:    k_prop    = longint'($signed(value));
                CFG_KI_SCALED: ki_scaled = longint'($signed(value));
                CFG_KD_SCALED: kd_scaled = longint'($signed(value));
                default: ;
            endcase
        endfunction

        // Signed error of bearing b against set point s, wrapped around the turn
        function longint wrapped_error(longint b, longint s);
            if (s >= HALF) begin
                if (b >= s - HALF && b <= s) return b - s;
                if (b >= s) return b - s;
                return b + TURN - s;
            end
            if (b >= s && b - HALF <= s) return b - s;
            if (b <= HALF) return b - s;
            return b - TURN - s;
        endfunction

        function longint clamp_drive(longint v);
            if (v > DRIVE_LIMIT) return DRIVE_LIMIT;
            if (v < -DRIVE_LIMIT) return -DRIVE_LIMIT;
            return v;
        endfunction

        // Advance the predicted state by one accepted tick and queue its result
        function void note_tick(t_in_word w);
            longint    bearing, err, acc, change, lset, rset, smax, smin;
            t_out_word res;
            bearing = w.bearing_tenths;
            if (bearing >= TURN) bearing -= TURN;
            err = 0;
            if (w.hold_enable) begin
                smax = (longint'(1) <<< (SUM_W - 1)) - 1;
                smin = -smax - 1;
                if (!hold_on) begin
                    held_bearing = bearing;
                    held_left    = left_sent;
                    held_right   = right_sent;
                    hold_on      = 1'b1;
                end
                err = wrapped_error(bearing, held_bearing);
                err_sum += err;
                if (err_sum > smax) err_sum = smax;
                if (err_sum < smin) err_sum = smin;
                acc = k_prop * err + ki_scaled * err_sum + kd_scaled * (err_sum - prev_sum);
                // truncate toward zero
                change   = (acc < 0) ? -((-acc) >>> 8) : (acc >>> 8);
                prev_sum = err_sum;
                lset = held_left;
                rset = held_right;
                if (change < 0) rset = (rset > 0) ? rset + change : rset - change;
                else if (change > 0) lset = (lset > 0) ? lset - change : lset + change;
            end else begin
                hold_on = 1'b0;
                lset    = w.left_request;
                rset    = w.right_request;
            end
            lset = clamp_drive(lset);
            rset = clamp_drive(rset);
            res.left_drive    = 8'(lset);
            res.right_drive   = 8'(rset);
            res.left_changed  = (lset != left_sent);
            res.right_changed = (rset != right_sent);
            res.heading_error = 12'(err);
            left_sent  = lset;
            right_sent = rset;
            expected_drives.push_back(res);
        endfunction

        function void check_drives(t_out_word got);
            t_out_word want;
            if (expected_drives.size() == 0) begin
                drive_mismatches++;
                if (drive_mismatches <= 10)
                    $display("%0t: result word with nothing expected: L=%0d R=%0d err=%0d",
                             $time, got.left_drive, got.right_drive, got.heading_error);
                return;
            end
            want = expected_drives.pop_front();
            if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive
                || got.left_changed !== want.left_changed
                || got.right_changed !== want.right_changed
                || got.heading_error !== want.heading_error) begin
                drive_mismatches++;
                if (drive_mismatches <= 10)
                    $display({"%0t: mismatch: expected L=%0d R=%0d lc=%0b rc=%0b err=%0d, ",
                              "got L=%0d R=%0d lc=%0b rc=%0b err=%0d"}, $time,
                             want.left_drive, want.right_drive, want.left_changed,
                             want.right_changed, want.heading_error,
                             got.left_drive, got.right_drive, got.left_changed,
                             got.right_changed, got.heading_error);
            end
        endfunction

        function int words_pending();
            return expected_drives.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_word   in_word   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    t_cfg_index cfg_index = CFG_K_PROP;
    logic [15:0] cfg_data = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_word  out_word;

    bit steady        = 1'b0;   // no random idling on either side while set
    bit stall_request = 1'b0;   // ask the receiver for one long hold-off
    int stall_cycles  = 0;

    drive_scoreboard sb = new();

    heading_hold_pid_differential_drive #(
        .SUM_WIDTH(SUM_W)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: check every accepted result word, drop ready at random or for
    // one long stretch when the stimulus asks for it.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_drives(out_word);
            if (stall_request) begin
                stall_cycles  = STALL_LEN;
                stall_request = 1'b0;
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady || ($urandom_range(99) >= 8);
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic t_in_word make_tick(int bearing, bit hold, int lreq, int rreq);
        t_in_word w;
        w.bearing_tenths = 12'(bearing);
        w.hold_enable    = hold;
        w.left_request   = 8'(lreq);
        w.right_request  = 8'(rreq);
        return w;
    endfunction

    // Offer one tick, with an occasional idle gap first; return once accepted.
    // Valid stays high between back-to-back ticks.
    task automatic send_tick(input t_in_word w);
        int gap;
        gap = 0;
        if (!steady) while ($urandom_range(99) < 8) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_tick(w);
    endtask

    // Write all three gains back to back; only called while the block is idle
    task automatic load_gains(int kp, int ki, int kd);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_K_PROP;
        cfg_data  <= 16'(kp);
        @(posedge clk);
        sb.set_gain(CFG_K_PROP, 16'(kp));
        cfg_index <= CFG_KI_SCALED;
        cfg_data  <= 16'(ki);
        @(posedge clk);
        sb.set_gain(CFG_KI_SCALED, 16'(ki));
        cfg_index <= CFG_KD_SCALED;
        cfg_data  <= 16'(kd);
        @(posedge clk);
        sb.set_gain(CFG_KD_SCALED, 16'(kd));
        cfg_we <= 1'b0;
    endtask

    // Hold the sender back until every predicted word has come out
    task automatic drain_results();
        while (sb.words_pending() != 0) @(posedge clk);
    endtask

    // One hold sequence: the first tick sits on the anchor, then bearings drift or
    // push around it or range freely. A few ticks drop hold to break the sequence.
    task automatic send_hold_run(int len, run_kind_e kind);
        int anchor, offset, x;
        anchor = $urandom_range(3599);
        offset = 1500 + $urandom_range(300);
        if ($urandom_range(1)) offset = -offset;
        for (int i = 0; i < len; i++) begin
            case (kind)
                RUN_DRIFT: x = anchor + int'($urandom_range(600)) - 300;
                RUN_PUSH:  x = anchor + offset + int'($urandom_range(40)) - 20;
                default:   x = $urandom_range(3599);
            endcase
            if (i == 0) x = anchor;
            x = ((x % 3600) + 3600) % 3600;
            // alias into the out-of-range band now and then
            if (x < 496 && $urandom_range(99) < 10) x += 3600;
            send_tick(make_tick(x, ($urandom_range(99) >= 3), $urandom, $urandom));
        end
    endtask

    task automatic run_phase(int n_items);
        int        left_items, len, pick;
        run_kind_e kind;
        left_items = n_items;
        while (left_items > 0) begin
            if ($urandom_range(99) < 15) begin
                // pass-through ticks with raw requests
                len = $urandom_range(4, 1);
                if (len > left_items) len = left_items;
                repeat (len)
                    send_tick(make_tick($urandom_range(4095), 1'b0, $urandom, $urandom));
            end else begin
                len  = $urandom_range(40, 1);
                if (len > left_items) len = left_items;
                pick = $urandom_range(99);
                kind = (pick < 60) ? RUN_DRIFT : (pick < 80) ? RUN_PUSH : RUN_WIDE;
                send_hold_run(len, kind);
            end
            left_items -= len;
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        int spins;

        // Reset once, then release
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at the reset gains (k_prop = 1.0)
        send_tick(make_tick(0, 1'b0, -128, 127));     // requests beyond the clamp
        send_tick(make_tick(0, 1'b0, 127, -128));
        send_tick(make_tick(0, 1'b0, 0, 0));
        send_tick(make_tick(0, 1'b0, 100, -60));      // drives to be latched
        send_tick(make_tick(0, 1'b1, 0, 0));          // latch set point 0
        send_tick(make_tick(1800, 1'b1, 0, 0));       // half turn ahead
        send_tick(make_tick(1801, 1'b1, 0, 0));       // just past half turn: wrap
        send_tick(make_tick(3599, 1'b1, 0, 0));
        send_tick(make_tick(4095, 1'b1, 0, 0));       // out-of-range bearing
        send_tick(make_tick(3600, 1'b1, 0, 0));
        send_tick(make_tick(2700, 1'b0, -125, 125));  // hold off, sums kept
        send_tick(make_tick(2700, 1'b1, 0, 0));       // latched bearing in upper half
        send_tick(make_tick(0, 1'b1, 0, 0));
        send_tick(make_tick(900, 1'b1, 0, 0));
        send_tick(make_tick(3599, 1'b1, 0, 0));
        send_tick(make_tick(899, 1'b1, 0, 0));
        send_tick(make_tick(2699, 1'b1, 0, 0));
        send_tick(make_tick(0, 1'b0, -1, 1));
        send_tick(make_tick(1799, 1'b1, 0, 0));       // latch just below half turn
        send_tick(make_tick(3599, 1'b1, 0, 0));
        send_tick(make_tick(3600, 1'b1, 0, 0));
        send_tick(make_tick(4000, 1'b1, 0, 0));
        send_tick(make_tick(0, 1'b0, -126, 126));
        send_tick(make_tick(0, 1'b0, -126, 126));     // unchanged drives: no flags
        in_valid <= 1'b0;
        drain_results();

        // Random phases, each under its own gain setting
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: load_gains(256, 0, 0);
                1: load_gains(32767, 32767, 32767);
                2: load_gains(-32768, -32768, -32768);
                4: load_gains(0, 0, 0);
                6: load_gains(0, int'($urandom_range(64)) - 32, 0);
                7: load_gains(0, 0, int'($urandom_range(512)) - 256);
                8: load_gains($urandom_range(65535), $urandom_range(65535),
                              $urandom_range(65535));
                default: load_gains(int'($urandom_range(1024)) - 512,
                                    int'($urandom_range(64)) - 32,
                                    int'($urandom_range(512)) - 256);
            endcase
            // Phase 3: receiver holds off while the sender keeps offering.
            // Phase 5: a long stretch with no idling on either side.
            steady = (phase == 3 || phase == 5);
            if (phase == 3) stall_request = 1'b1;
            run_phase(PHASE_ITEMS);
            drain_results();
            steady = 1'b0;
        end

        // Let the last words settle, bounded
        spins = 0;
        while (sb.words_pending() != 0 && spins < 5000) begin
            @(posedge clk);
            spins++;
        end
        repeat (4) @(posedge clk);
        if (sb.words_pending() != 0)
            $display("%0d expected words never arrived", sb.words_pending());

        if (sb.drive_mismatches == 0 && sb.words_pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ heading_hold_pid_differential_drive.f @@
src/hhpid_pkg.sv
src/hhpid_error.sv
src/hhpid_drive.sv
src/heading_hold_pid_differential_drive.sv
tb/tb.sv
